[rtl/tsel_pkg.sv]
// ----------------------------------------------------------------------------
// tsel_pkg
// Shared types, constants and helpers of the tournament selection block.
// ----------------------------------------------------------------------------
package tsel_pkg;

  localparam int unsigned POPULATION_MAX_DEF = 1024;
  localparam int unsigned COST_BITS_DEF      = 32;
  localparam int unsigned TOURNAMENT_MAX_DEF = 16;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COST_W     = 32;
  localparam int unsigned TSIZE_W    = 5;
  localparam int unsigned POP_W      = 11;
  localparam int unsigned LFSR_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam int unsigned MOD_RADIX_BITS = 4;
  localparam int unsigned MOD_CYCLES     = LFSR_W / MOD_RADIX_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOURNAMENT_SIZE = 2'd0,
    CFG_POPULATION_SIZE = 2'd1,
    CFG_RANDOM_SEED     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SELECT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_CMP
  } sel_state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [COST_W-1:0] entry_cost;
  } sel_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  winner_index;
    logic [COST_W-1:0] winner_cost;
  } sel_out_t;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [POP_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [POP_W-1:0] remainder;
  } mod_rsp_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] sh;
    sh = {1'b0, s[LFSR_W-1:1]};
    return s[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

endpackage

[rtl/tsel_mod.sv]
// ----------------------------------------------------------------------------
// tsel_mod
// Iterative remainder unit: radix-2 restoring steps, one nibble a cycle.
// ----------------------------------------------------------------------------
module tsel_mod import tsel_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int unsigned CNT_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_CYCLES - 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [LFSR_W-1:0] shreg_q, shreg_d;
  logic [POP_W-1:0]  rem_q, rem_d;
  logic [POP_W-1:0]  div_q;

  always_comb begin
    logic [POP_W:0]    t;
    logic [POP_W-1:0]  r;
    logic [LFSR_W-1:0] sh;
    r  = rem_q;
    sh = shreg_q;
    for (int i = 0; i < MOD_RADIX_BITS; i++) begin
      t  = {r, sh[LFSR_W-1]};
      sh = {sh[LFSR_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[POP_W-1:0];
    end
    rem_d   = r;
    shreg_d = sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      shreg_q <= req_i.dividend;
      rem_q   <= '0;
      div_q   <= req_i.divisor;
    end else if (busy_q) begin
      shreg_q <= shreg_d;
      rem_q   <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[rtl/tsel_mem.sv]
// ----------------------------------------------------------------------------
// tsel_mem
// Cost store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsel_mem import tsel_pkg::*; #(
  parameter int unsigned DEPTH = POPULATION_MAX_DEF,
  parameter int unsigned WIDTH = COST_BITS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tournament_selection.sv]
// ----------------------------------------------------------------------------
// tournament_selection
// A load transfer writes the cost store when accepted. A select transfer
// runs one draw per tournament entry (remainder, done, store read, compare),
// then waits while a held result is stalled; the next transfer can follow
// in the cycle after the result loads. Reset sets the tournament size to 2,
// population to 1024 and LFSR to 1; the cost store holds nothing until written.
// ----------------------------------------------------------------------------
module tournament_selection import tsel_pkg::*; #(
  parameter int unsigned POPULATION_MAX = POPULATION_MAX_DEF,
  parameter int unsigned COST_BITS      = COST_BITS_DEF,
  parameter int unsigned TOURNAMENT_MAX = TOURNAMENT_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sel_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sel_out_t              out_data_o
);

  localparam int unsigned AW = $clog2(POPULATION_MAX);
  localparam int unsigned TW = $clog2(TOURNAMENT_MAX + 1);

  sel_state_e           state_q, state_d;
  logic [TSIZE_W-1:0]   tsize_q;
  logic [POP_W-1:0]     pop_q;
  logic [LFSR_W-1:0]    lfsr_q;
  logic [TW-1:0]        draw_q;
  logic [AW-1:0]        slot_q;
  logic [AW-1:0]        best_idx_q;
  logic [COST_BITS-1:0] best_cost_q;
  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic [COST_W-1:0]    out_cost_q;

  int unsigned          tsize_int;
  int unsigned          pop_int;
  logic [TW-1:0]        draws_eff;
  logic [POP_W-1:0]     pop_eff;

  logic                 in_acc;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [COST_BITS-1:0] mem_wdata;
  logic [COST_BITS-1:0] mem_rdata;
  logic [AW-1:0]        slot;
  logic [31:0]          idx_ext;
  logic [31:0]          rem_ext;
  logic [63:0]          cost_in_ext;
  logic [63:0]          cost_out_ext;
  logic [31:0]          win_idx_ext;

  logic                 better;
  logic                 last_draw;
  logic                 draw_clr;
  logic                 draw_inc;
  logic                 out_load;
  logic                 mod_start;
  logic [AW-1:0]        win_idx;
  logic [COST_BITS-1:0] win_cost;

  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;

  // Clamp the configured sizes to their legal ranges.
  always_comb begin
    tsize_int = 32'(tsize_q);
    if (tsize_int == 0) begin
      tsize_int = 1;
    end
    if (tsize_int > TOURNAMENT_MAX) begin
      tsize_int = TOURNAMENT_MAX;
    end
    draws_eff = TW'(tsize_int);

    pop_int = 32'(pop_q);
    if (pop_int == 0) begin
      pop_int = 1;
    end
    if (pop_int > POPULATION_MAX) begin
      pop_int = POPULATION_MAX;
    end
    pop_eff = POP_W'(pop_int);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_ext     = 32'(in_data_i.entry_index);
  assign cost_in_ext = 64'(in_data_i.entry_cost);
  assign mem_waddr   = idx_ext[AW-1:0];
  assign mem_wdata   = cost_in_ext[COST_BITS-1:0];
  assign mem_we      = in_acc && (in_data_i.cmd == CMD_LOAD) && (idx_ext < POPULATION_MAX);

  assign rem_ext = 32'(mod_rsp.remainder);
  assign slot    = rem_ext[AW-1:0];

  assign better    = (draw_q == '0) || (mem_rdata < best_cost_q);
  assign last_draw = (draw_q == draws_eff - 1'b1);
  assign win_idx   = better ? slot_q : best_idx_q;
  assign win_cost  = better ? mem_rdata : best_cost_q;

  assign mod_req.start    = mod_start;
  assign mod_req.dividend = lfsr_next(lfsr_q);
  assign mod_req.divisor  = pop_eff;

  always_comb begin
    state_d   = state_q;
    mod_start = 1'b0;
    mem_re    = 1'b0;
    draw_clr  = 1'b0;
    draw_inc  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.cmd == CMD_SELECT)) begin
          mod_start = 1'b1;
          draw_clr  = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          mem_re  = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!last_draw) begin
          mod_start = 1'b1;
          draw_inc  = 1'b1;
          state_d   = S_MOD;
        end else if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tsize_q     <= TSIZE_W'(2);
      pop_q       <= POP_W'(1024);
      lfsr_q      <= LFSR_W'(1);
      draw_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mod_start) begin
        lfsr_q <= mod_req.dividend;
      end
      if (draw_clr) begin
        draw_q <= '0;
      end else if (draw_inc) begin
        draw_q <= draw_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TOURNAMENT_SIZE: tsize_q <= cfg_data_i[TSIZE_W-1:0];
          CFG_POPULATION_SIZE: pop_q   <= cfg_data_i[POP_W-1:0];
          CFG_RANDOM_SEED: begin
            lfsr_q <= (cfg_data_i == '0) ? LFSR_W'(1) : cfg_data_i;
          end
          default: ;
        endcase
      end
    end
  end

  assign cost_out_ext = 64'(win_cost);
  assign win_idx_ext  = 32'(win_idx);

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      slot_q <= slot;
    end
    if (draw_inc) begin
      best_idx_q  <= win_idx;
      best_cost_q <= win_cost;
    end
    if (out_load) begin
      out_idx_q  <= win_idx_ext[IDX_W-1:0];
      out_cost_q <= cost_out_ext[COST_W-1:0];
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.winner_index = out_idx_q;
  assign out_data_o.winner_cost  = out_cost_q;

  tsel_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  tsel_mem #(
    .DEPTH (POPULATION_MAX),
    .WIDTH (COST_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot),
    .rdata_o (mem_rdata)
  );

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("LFSR state is zero");

  a_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == S_MOD))
    else $error("remainder finished outside a draw");

  a_select_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.cmd == CMD_SELECT)) |=> (state_q == S_MOD))
    else $error("select transfer did not start a draw");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (32'(slot_q) < 32'(pop_eff)))
    else $error("drawn slot beyond population size");

endmodule

[sim/tournament_selection_test.sv]
// ----------------------------------------------------------------------------
// tournament_selection_test
// Self-checking bench for the tournament selection block. Cost entries are
// loaded before any selection can draw them, a directed pass walks the
// register extremes, ties and the saturating cases, and randomised phases mix
// loads and selections under bursty input and a stalling receiver. A
// scoreboard keeps its own cost store and LFSR and checks every winner in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tournament_selection_test;
  import tsel_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 500000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 65;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  class tournament_board;
    logic [COST_W-1:0] costs [POPULATION_MAX_DEF];
    bit                 written [POPULATION_MAX_DEF];
    logic [TSIZE_W-1:0] draws_reg;
    logic [POP_W-1:0]   pop_reg;
    logic [LFSR_W-1:0]  lfsr;
    sel_out_t           pending[$];
    int unsigned        errors;
    int unsigned        loads;
    int unsigned        selects;
    int unsigned        checked;

    function new();
      draws_reg = TSIZE_W'(2);
      pop_reg   = POP_W'(1024);
      lfsr      = LFSR_W'(1);
      errors    = 0;
      loads     = 0;
      selects   = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TOURNAMENT_SIZE: draws_reg = data[TSIZE_W-1:0];
        CFG_POPULATION_SIZE: pop_reg = data[POP_W-1:0];
        CFG_RANDOM_SEED:     lfsr = (data == '0) ? LFSR_W'(1) : data;
        default: ;
      endcase
    endfunction

    function logic [LFSR_W-1:0] advance(logic [LFSR_W-1:0] s);
      return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

    // First slot the next selection would draw that holds no cost yet.
    function int unsigned first_gap();
      int unsigned draws;
      int unsigned pop;
      int unsigned slot;
      logic [LFSR_W-1:0] s;
      draws = (draws_reg == 0) ? 1 :
              ((draws_reg > TOURNAMENT_MAX_DEF) ? TOURNAMENT_MAX_DEF : draws_reg);
      pop   = (pop_reg == 0) ? 1 :
              ((pop_reg > POPULATION_MAX_DEF) ? POPULATION_MAX_DEF : pop_reg);
      s = lfsr;
      for (int j = 0; j < draws; j++) begin
        s    = advance(s);
        slot = s % pop;
        if (!written[slot]) return slot;
      end
      return POPULATION_MAX_DEF;
    endfunction

    function sel_out_t play_tournament();
      int unsigned draws;
      int unsigned pop;
      int unsigned slot;
      logic [COST_W-1:0] c;
      sel_out_t w;
      draws = (draws_reg == 0) ? 1 :
              ((draws_reg > TOURNAMENT_MAX_DEF) ? TOURNAMENT_MAX_DEF : draws_reg);
      pop   = (pop_reg == 0) ? 1 :
              ((pop_reg > POPULATION_MAX_DEF) ? POPULATION_MAX_DEF : pop_reg);
      w = '0;
      for (int j = 0; j < draws; j++) begin
        lfsr = advance(lfsr);
        slot = lfsr % pop;
        c    = costs[slot];
        if (j == 0 || c < w.winner_cost) begin
          w.winner_index = IDX_W'(slot);
          w.winner_cost  = c;
        end
      end
      return w;
    endfunction

    function void take_entry(sel_in_t it);
      if (it.cmd == CMD_LOAD) begin
        costs[it.entry_index]   = it.entry_cost;
        written[it.entry_index] = 1'b1;
        loads++;
      end else begin
        pending.push_back(play_tournament());
        selects++;
      end
    endfunction

    function void judge_winner(sel_out_t got);
      sel_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected winner, got index %0d cost %h", $time,
                 got.winner_index, got.winner_cost);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.winner_index !== exp.winner_index) begin
        $display("%0t: winner_index expected %0d, got %0d", $time,
                 exp.winner_index, got.winner_index);
        errors++;
      end
      if (got.winner_cost !== exp.winner_cost) begin
        $display("%0t: winner_cost expected %h, got %h", $time,
                 exp.winner_cost, got.winner_cost);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  sel_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sel_out_t              out_data_o;

  tournament_board board;
  int unsigned     cycles      = 0;
  int unsigned     burst_left  = 0;
  int unsigned     cfg_writes  = 0;
  int unsigned     hold_asks   = 0;
  int unsigned     hold_done   = 0;
  int unsigned     hold_left   = 0;
  int unsigned     mode_left   = 0;
  rx_mode_e        stall_mode  = RX_FLOW;

  tournament_selection uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tournament_selection_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.judge_winner(out_data_o);
    end
  end

  always @(negedge clk_i) begin
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        RX_FLOW:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:  out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic send_item(input sel_in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.take_entry(it);
  endtask

  task automatic settle();
    idle_sender(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    board.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Fill the bits above the register width with noise.
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] v,
                                                      input int unsigned w);
    logic [CFG_DATA_W-1:0] m;
    m = (32'h1 << w) - 1;
    return ($urandom & ~m) | (v & m);
  endfunction

  task automatic set_shape(input int unsigned draws, input int unsigned pop);
    write_reg(CFG_TOURNAMENT_SIZE, with_noise(draws, TSIZE_W));
    write_reg(CFG_POPULATION_SIZE, with_noise(pop, POP_W));
  endtask

  function automatic sel_in_t load_of(input int unsigned idx, input logic [COST_W-1:0] c);
    sel_in_t it;
    it.cmd         = CMD_LOAD;
    it.entry_index = IDX_W'(idx);
    it.entry_cost  = c;
    return it;
  endfunction

  function automatic sel_in_t select_item();
    sel_in_t it;
    it.cmd         = CMD_SELECT;
    it.entry_index = IDX_W'($urandom);
    it.entry_cost  = $urandom;
    return it;
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Load every empty slot the selection will draw, then send it.
  task automatic send_select();
    int unsigned gap;
    gap = board.first_gap();
    while (gap < POPULATION_MAX_DEF) begin
      send_item(load_of(gap, pick_cost()));
      gap = board.first_gap();
    end
    send_item(select_item());
  endtask

  function automatic sel_in_t random_item(input int unsigned pop);
    if ($urandom_range(0, 9) < 6) return select_item();
    if ($urandom_range(0, 3) != 0) return load_of($urandom_range(0, pop - 1), pick_cost());
    return load_of($urandom_range(0, POPULATION_MAX_DEF - 1), pick_cost());
  endfunction

  initial begin
    int unsigned draws;
    int unsigned pop;
    int unsigned pop_eff;
    int unsigned phase_end;
    sel_in_t     it;
    board = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    repeat (3) send_select();

    settle();
    set_shape(1, 1);
    send_item(load_of(0, '0));
    send_item(select_item());
    send_item(load_of(0, '1));
    send_item(select_item());

    settle();
    set_shape(0, 0);
    repeat (2) send_item(select_item());

    settle();
    set_shape(TOURNAMENT_MAX_DEF, 2);
    send_item(load_of(0, 5));
    send_item(load_of(1, 5));
    repeat (2) send_item(select_item());
    send_item(load_of(1, 4));
    send_item(select_item());

    settle();
    set_shape(31, 2047);
    write_reg(CFG_RANDOM_SEED, '0);
    repeat (2) send_select();

    settle();
    set_shape(TOURNAMENT_MAX_DEF + 1, POPULATION_MAX_DEF + 1);
    write_reg(CFG_RANDOM_SEED, '1);
    write_reg(CFG_SPARE, $urandom);
    repeat (2) send_select();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          draws = TOURNAMENT_MAX_DEF;
          pop   = POPULATION_MAX_DEF;
        end
        1: begin
          draws = 1;
          pop   = $urandom_range(1, POPULATION_MAX_DEF);
        end
        2: begin
          draws = $urandom_range(1, TOURNAMENT_MAX_DEF);
          pop   = $urandom_range(1, 8);
        end
        default: begin
          draws = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(1, TOURNAMENT_MAX_DEF);
          pop   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(1, POPULATION_MAX_DEF);
        end
      endcase
      set_shape(draws, pop);
      if (p < 2 || $urandom_range(0, 1) == 1) write_reg(CFG_RANDOM_SEED, $urandom);
      pop_eff = (pop == 0) ? 1 : ((pop > POPULATION_MAX_DEF) ? POPULATION_MAX_DEF : pop);
      if (p == 2) hold_asks <= hold_asks + 1;
      phase_end = board.loads + board.selects + PHASE_ITEMS;
      while (board.loads + board.selects < phase_end) begin
        it = random_item(pop_eff);
        if (it.cmd == CMD_SELECT) begin
          send_select();
        end else begin
          send_item(it);
        end
      end
    end

    idle_sender(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d cost loads and %0d tournaments across %0d register writes,",
             board.loads, board.selects, cfg_writes);
    $display("%0d winners checked with %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tournament_selection_test: PASS");
    end else begin
      $display("tournament_selection_test: FAIL");
    end
    $finish;
  end

endmodule
